// File: sv/ntlae_pkg.sv
// ----------------------------------------------------------------------------
// ntlae_pkg
// Shared constants, codes and types of the node table.
// ----------------------------------------------------------------------------
package ntlae_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = 5;
    localparam int ID_W    = 32;
    localparam int TIME_W  = 32;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_PLAIN      = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TIME   = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_UNREAD = 2'd2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [TIME_W-1:0] t_time;

    typedef struct packed {
        logic  set_time;
        logic  set_unread;
        t_id   node_id;
        t_time heard_time;
    } t_req;

    typedef struct packed {
        logic busy;
        logic full;
        t_cnt fill;
    } t_stat;

endpackage

// File: sv/ntlae_if.sv
// ----------------------------------------------------------------------------
// ntlae_if
// Request and response channels of the node table.
// ----------------------------------------------------------------------------
interface ntlae_req_if import ntlae_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    t_id             node_id;
    t_time           heard_time;

    modport source (output valid, operation, node_id, heard_time, input ready);
    modport sink   (input valid, operation, node_id, heard_time, output ready);
endinterface

interface ntlae_rsp_if import ntlae_pkg::*; ();
    logic  valid;
    logic  ready;
    t_slot slot;
    logic  hit;
    logic  evicted;
    t_id   evicted_id;
    logic  unread_flag;

    modport source (output valid, slot, hit, evicted, evicted_id, unread_flag, input ready);
    modport sink   (input valid, slot, hit, evicted, evicted_id, unread_flag, output ready);
endinterface

// File: sv/ntlae_front.sv
// ----------------------------------------------------------------------------
// ntlae_front
// Accepts requests, decodes the operation and registers them for the queue.
// ----------------------------------------------------------------------------
module ntlae_front import ntlae_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntlae_req_if.sink   i_req,
    output logic        o_push,
    output t_req        o_push_req,
    input  logic        i_push_ready
);

    logic r_valid;
    t_req r_req;
    t_req n_req;
    logic take;

    assign i_req.ready = !r_valid || i_push_ready;
    assign take        = i_req.valid && i_req.ready;

    always_comb begin
        n_req            = '0;
        n_req.node_id    = i_req.node_id;
        n_req.heard_time = i_req.heard_time;
        case (i_req.operation)
            OP_SET_TIME:   n_req.set_time   = 1'b1;
            OP_SET_UNREAD: n_req.set_unread = 1'b1;
            OP_PLAIN:      n_req.set_time   = 1'b0;
            default:       n_req.set_time   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= n_req;
        end
    end

    assign o_push     = r_valid;
    assign o_push_req = r_req;

endmodule

// File: sv/ntlae_queue.sv
// ----------------------------------------------------------------------------
// ntlae_queue
// Two-entry request queue between the front and the lookup engine.
// ----------------------------------------------------------------------------
module ntlae_queue import ntlae_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_push_req,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_req o_pop_req,
    input  logic i_pop
);

    t_req       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_req    = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

// File: sv/ntlae_back.sv
// ----------------------------------------------------------------------------
// ntlae_back
// Lookup engine: scans the slot memories, picks hit, free or oldest slot,
// writes back and registers the response.
// ----------------------------------------------------------------------------
module ntlae_back import ntlae_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    input  t_req        i_pop_req,
    output logic        o_pop,
    ntlae_rsp_if.source o_rsp,
    output t_stat       o_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    t_id   mem_id     [ENTRIES];
    t_time mem_time   [ENTRIES];
    logic  mem_unread [ENTRIES];

    logic [1:0] r_state;
    t_cnt       r_fill;
    t_req       r_req;
    t_cnt       r_rd_idx;
    logic       r_pend;
    t_idx       r_pend_idx;
    t_id        r_rd_id;
    t_time      r_rd_time;
    logic       r_rd_unread;
    logic       r_hit;
    t_idx       r_hit_idx;
    logic       r_hit_unread;
    t_time      r_min;
    t_idx       r_min_idx;
    t_id        r_min_id;

    logic       r_out_valid;
    t_slot      r_out_slot;
    logic       r_out_hit;
    logic       r_out_evicted;
    t_id        r_out_evicted_id;
    logic       r_out_unread;

    logic full;
    logic issue;
    logic hit_now;
    logic out_free;
    logic finish;
    t_idx n_idx;
    logic n_evicted;
    t_id  n_evicted_id;
    logic n_unread;
    logic wr_id;
    logic wr_time;
    logic wr_unread;
    t_time wr_time_val;

    assign full     = (r_fill == t_cnt'(ENTRIES));
    assign hit_now  = r_pend && !r_hit && (r_rd_id == r_req.node_id);
    assign issue    = (r_state == ST_SCAN) && (r_rd_idx < r_fill) && !r_hit && !hit_now;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign finish   = (r_state == ST_DONE) && out_free;
    assign o_pop    = (r_state == ST_IDLE) && i_pop_valid;

    always_comb begin
        n_idx        = r_hit_idx;
        n_evicted    = 1'b0;
        n_evicted_id = '0;
        if (!r_hit) begin
            if (!full) begin
                n_idx = r_fill[IDX_W-1:0];
            end else begin
                n_idx        = r_min_idx;
                n_evicted    = 1'b1;
                n_evicted_id = r_min_id;
            end
        end
        n_unread    = r_req.set_unread || (r_hit && r_hit_unread);
        wr_id       = finish && !r_hit;
        wr_time     = finish && (!r_hit || r_req.set_time);
        wr_unread   = finish && (!r_hit || r_req.set_unread);
        wr_time_val = r_req.set_time ? r_req.heard_time : '0;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_id <= mem_id[r_rd_idx[IDX_W-1:0]];
        end
        if (wr_id) begin
            mem_id[n_idx] <= r_req.node_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_time <= mem_time[r_rd_idx[IDX_W-1:0]];
        end
        if (wr_time) begin
            mem_time[n_idx] <= wr_time_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_unread <= mem_unread[r_rd_idx[IDX_W-1:0]];
        end
        if (wr_unread) begin
            mem_unread[n_idx] <= r_req.set_unread;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        r_rd_idx <= '0;
                        r_pend   <= 1'b0;
                        r_hit    <= 1'b0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_pend_idx <= r_rd_idx[IDX_W-1:0];
                        r_rd_idx   <= r_rd_idx + t_cnt'(1);
                    end
                    if (hit_now) begin
                        r_hit <= 1'b1;
                    end
                    if (!issue && !r_pend) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (!r_hit && !full) begin
                            r_fill <= r_fill + t_cnt'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_pop_req;
        end
        if (hit_now) begin
            r_hit_idx    <= r_pend_idx;
            r_hit_unread <= r_rd_unread;
        end
        if (r_state == ST_SCAN && r_pend && !r_hit) begin
            if (r_pend_idx == '0 || r_rd_time < r_min) begin
                r_min     <= r_rd_time;
                r_min_idx <= r_pend_idx;
                r_min_id  <= r_rd_id;
            end
        end
        if (finish) begin
            r_out_slot       <= t_slot'(n_idx);
            r_out_hit        <= r_hit;
            r_out_evicted    <= n_evicted;
            r_out_evicted_id <= n_evicted_id;
            r_out_unread     <= n_unread;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.slot        = r_out_slot;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_id  = r_out_evicted_id;
    assign o_rsp.unread_flag = r_out_unread;

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.full = full;
    assign o_stat.fill = r_fill;

endmodule

// File: sv/node_table_lookup_allocate_evict.sv
// ----------------------------------------------------------------------------
// node_table_lookup_allocate_evict
// Fully associative node directory with oldest-time replacement.
// ----------------------------------------------------------------------------
// i_req carries one request: operation, node_id and heard_time. o_rsp returns
// one response per request, in order: slot, hit, evicted, evicted_id and
// unread_flag. Both channels move a request when valid and ready are high.
// The front registers and decodes each request into a two-entry queue; the
// lookup engine pops one request at a time and scans the filled slots, one
// slot per cycle through the id, time and unread memories, stopping at the
// first match. A miss in a full table scans it end to end for the oldest slot.
// The engine pops the next request only once it has registered the response
// to the last; front and queue hold requests ahead of the pop. Reset empties
// the table (fill count zero); slot memories are not cleared and are only
// read once written. A stalled receiver holds the response register; the
// engine then waits before write-back, while the front and queue keep taking
// up to three further requests.
// ----------------------------------------------------------------------------
module node_table_lookup_allocate_evict import ntlae_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntlae_req_if.sink   i_req,
    ntlae_rsp_if.source o_rsp
);

    logic  push;
    t_req  push_req;
    logic  push_ready;
    logic  pop_valid;
    t_req  pop_req;
    logic  pop;
    t_stat stat;

    ntlae_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push       (push),
        .o_push_req   (push_req),
        .i_push_ready (push_ready)
    );

    ntlae_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_req   (push_req),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_req    (pop_req),
        .i_pop        (pop)
    );

    ntlae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_req   (pop_req),
        .o_pop       (pop),
        .o_rsp       (o_rsp),
        .o_stat      (stat)
    );

    a_evict_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.evicted |-> stat.full)
        else $error("eviction reported while table not full");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.hit && o_rsp.evicted))
        else $error("hit and eviction reported together");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.fill <= t_cnt'(ENTRIES))
        else $error("fill count beyond table size");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !stat.busy && pop_valid)
        else $error("queue popped while engine busy");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the node table with lookup, allocation and oldest-time eviction.
// A shadow copy of the table predicts slot, hit, eviction and unread flag for
// every accepted request. Each response is checked in order against it. The
// stimulus is a directed start, then random traffic over a small pool of node
// ids so that hits, fills and evictions all occur. Both channels stall at
// random, apart from a quiet tail at the end of the run.
// ----------------------------------------------------------------------------
module tb;
    import ntlae_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int STALL_MAX       = 18;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 2 * (ENTRIES + 4);
    localparam int RANDOM_REQUESTS = 1850;
    localparam int QUIET_TAIL      = 250;
    localparam int POOL_SIZE       = 48;

    typedef struct packed {
        t_slot slot;
        logic  hit;
        logic  evicted;
        t_id   evicted_id;
        logic  unread_flag;
    } t_lookup_result;

    class directory_shadow;
        t_id            slot_id[ENTRIES];
        t_time          slot_time[ENTRIES];
        bit             slot_unread[ENTRIES];
        int             fill;
        int             errors;
        t_lookup_result awaited[$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, t_id id, t_time tm);
            t_lookup_result r;
            int             idx;
            bit             found;
            r     = '0;
            idx   = 0;
            found = 1'b0;
            for (int i = 0; i < fill; i++) begin
                if (!found && slot_id[i] == id) begin
                    idx   = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (fill < ENTRIES) begin
                    idx = fill;
                    fill++;
                end else begin
                    idx = 0;
                    for (int i = 1; i < ENTRIES; i++) begin
                        if (slot_time[i] < slot_time[idx]) idx = i;
                    end
                    r.evicted    = 1'b1;
                    r.evicted_id = slot_id[idx];
                end
                slot_id[idx]     = id;
                slot_time[idx]   = '0;
                slot_unread[idx] = 1'b0;
            end
            if (op == OP_SET_TIME) begin
                slot_time[idx] = tm;
            end else if (op == OP_SET_UNREAD) begin
                slot_unread[idx] = 1'b1;
            end
            r.slot        = t_slot'(idx);
            r.hit         = found;
            r.unread_flag = slot_unread[idx];
            awaited.push_back(r);
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endfunction

        function void check_response(t_lookup_result got);
            t_lookup_result want;
            if (awaited.size() == 0) begin
                report($sformatf("response with no request waiting, slot %0d", got.slot));
                return;
            end
            want = awaited.pop_front();
            if (got.slot !== want.slot)
                report($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.hit !== want.hit)
                report($sformatf("hit %b, want %b", got.hit, want.hit));
            if (got.evicted !== want.evicted)
                report($sformatf("evicted %b, want %b", got.evicted, want.evicted));
            if (got.evicted_id !== want.evicted_id)
                report($sformatf("evicted_id %h, want %h", got.evicted_id, want.evicted_id));
            if (got.unread_flag !== want.unread_flag)
                report($sformatf("unread_flag %b, want %b", got.unread_flag, want.unread_flag));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ntlae_req_if req_if ();
    ntlae_rsp_if rsp_if ();

    node_table_lookup_allocate_evict DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    directory_shadow shadow;
    t_lookup_result  seen;
    t_id             id_pool[POOL_SIZE];
    bit              quiet_tail;
    int              gap_rate;
    int              ready_hold;
    int              idle_cycles;
    bit              req_taken;
    bit              rsp_taken;

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (quiet_tail) begin
            rsp_if.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, STALL_MAX - 1);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            req_taken = (req_if.valid === 1'b1) && (req_if.ready === 1'b1);
            rsp_taken = (rsp_if.valid === 1'b1) && (rsp_if.ready === 1'b1);
            if (req_taken)
                shadow.note_request(req_if.operation, req_if.node_id, req_if.heard_time);
            if (rsp_taken) begin
                seen.slot        = rsp_if.slot;
                seen.hit         = rsp_if.hit;
                seen.evicted     = rsp_if.evicted;
                seen.evicted_id  = rsp_if.evicted_id;
                seen.unread_flag = rsp_if.unread_flag;
                shadow.check_response(seen);
            end
            if (req_taken || rsp_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input t_id id,
                                input t_time tm, input int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.node_id    <= id;
        req_if.heard_time <= tm;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic drain_responses();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (shadow.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_operation();
        case ($urandom_range(0, 9))
            0, 1, 2: return OP_PLAIN;
            3, 4, 5: return OP_SET_TIME;
            6, 7, 8: return OP_SET_UNREAD;
            default: return OP_SPARE;
        endcase
    endfunction

    function automatic t_id pick_node_id();
        if ($urandom_range(0, 9) < 8) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic t_time pick_heard_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    initial begin
        shadow            = new();
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.operation  = OP_PLAIN;
        req_if.node_id    = '0;
        req_if.heard_time = '0;
        rsp_if.ready      = 1'b0;
        quiet_tail        = 1'b0;
        ready_hold        = 0;
        idle_cycles       = 0;
        gap_rate          = 0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(OP_PLAIN,      32'h0000_0000, 32'h0000_0000, 0);
        send_request(OP_SET_TIME,   32'h0000_0000, 32'hFFFF_FFFF, 0);
        send_request(OP_SET_UNREAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(OP_SPARE,      32'hFFFF_FFFF, 32'h1234_5678, 0);
        send_request(OP_SET_TIME,   32'h8000_0001, 32'h0000_0000, 0);
        send_request(OP_SET_UNREAD, 32'h0000_0000, 32'h0000_0000, 0);
        send_request(OP_SET_TIME,   32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_request(OP_SET_TIME,   32'hAAAA_AAAA, 32'h5555_5555, 0);
        send_request(OP_SPARE,      32'h0000_0001, 32'h0000_0007, 0);
        send_request(OP_PLAIN,      32'h8000_0001, 32'h0000_0000, 0);
        send_request(OP_SET_TIME,   32'hFFFF_FFFF, 32'h0000_0001, 0);
        send_request(OP_SET_UNREAD, 32'h5555_5555, 32'h0000_0000, 0);
        send_request(OP_PLAIN,      32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(OP_SET_TIME,   32'h0000_0001, 32'h8000_0000, 0);
        send_request(OP_PLAIN,      32'hAAAA_AAAA, 32'h0000_0000, 0);
        drain_responses();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0) gap_rate = $urandom_range(0, 3);
            if (n == RANDOM_REQUESTS / 2) drain_responses();
            if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet_tail = 1'b1;
            send_request(pick_operation(), pick_node_id(), pick_heard_time(),
                         (!quiet_tail && gap_rate != 0 && $urandom_range(0, 7) < gap_rate)
                             ? $urandom_range(1, STALL_MAX) : 0);
        end

        drain_responses();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (shadow.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/ntlae_pkg.sv
sv/ntlae_if.sv
sv/ntlae_front.sv
sv/ntlae_queue.sv
sv/ntlae_back.sv
sv/node_table_lookup_allocate_evict.sv
dv/tb.sv
